// File: design/alfu_pkg.sv
package alfu_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned FC_W  = 11;

  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [IDX_W-1:0]        found_index;
    logic signed [VAL_W-1:0] old_value;
    logic signed [VAL_W-1:0] new_value;
    logic [FC_W-1:0]         fill_count;
  } rsp_t;

endpackage

// File: design/array_list_find_update_append_remove_unit.sv
// Packed list of signed 32-bit words with a fill count, held in one
// single-port-read, single-port-write memory and walked by a small sequencer.
//
// Command channel: a transfer happens on a rising edge with start high and
// busy low; req carries command, index and value. Result channel: done is
// high for exactly one cycle with rsp valid; the receiver cannot stall it.
// Every command gives exactly one result.
//
// Steps from the accepting edge to the result:
//   append, rejected commands, remove of the last entry: no walk, result registered directly
//   modify: read old word, then write
//   find:   walk up from position 0 to the match, at most count entries
//   remove: shift the entries above index down, one word moved per cycle
// The memory read port sets the pace: one entry is read per cycle. busy is
// high while a command is running; a new command may be taken in the cycle
// its predecessor's result is shown.
//
// Reset empties the list (count goes to zero); memory contents are left as
// they are, since only positions below the count are ever used.
module array_list_find_update_append_remove_unit
  import alfu_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int unsigned FX_W   = (CNT_W > FC_W) ? CNT_W : FC_W;
  localparam int unsigned FIX_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_REM  = 2'd3;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data;

  logic [1:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [VAL_W-1:0]  key, key_next;
  logic              done_next;
  rsp_t              rsp_next;

  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [VAL_W-1:0]  wd;
  logic [ADDR_W-1:0] ra;

  logic [CMP_W-1:0]  idx_x;
  logic [CMP_W-1:0]  cnt_x;
  logic              accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign idx_x  = CMP_W'(req.index);
  assign cnt_x  = CMP_W'(count);

  always_comb begin
    logic [FX_W-1:0]  fx;
    logic [FIX_W-1:0] fi;
    state_next = state;
    count_next = count;
    ptr_next   = ptr;
    key_next   = key;
    done_next  = 1'b0;
    rsp_next   = rsp;
    we         = 1'b0;
    wa         = ptr;
    wd         = rd_data;
    ra         = ADDR_W'(idx_x);
    fx         = '0;
    fi         = '0;
    rsp_next.found_index = '0;
    rsp_next.old_value   = '0;
    rsp_next.new_value   = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          key_next = req.value;
          ptr_next = ADDR_W'(idx_x);
          unique case (req.command)
            CMD_FIND: begin
              ra       = '0;
              ptr_next = '0;
              if (count == '0) begin
                done_next       = 1'b1;
                rsp_next.status = ST_NOT_FOUND;
              end else begin
                state_next = S_FIND;
              end
            end
            CMD_MODIFY: begin
              if (idx_x >= cnt_x) begin
                done_next       = 1'b1;
                rsp_next.status = ST_RANGE;
              end else begin
                state_next = S_MOD;
              end
            end
            CMD_APPEND: begin
              if (count == CNT_W'(DEPTH)) begin
                done_next       = 1'b1;
                rsp_next.status = ST_FULL;
              end else begin
                we                 = 1'b1;
                wa                 = ADDR_W'(count);
                wd                 = req.value;
                count_next         = count + 1'b1;
                done_next          = 1'b1;
                rsp_next.status    = ST_OK;
                rsp_next.new_value = req.value;
              end
            end
            CMD_REMOVE: begin
              ra = ADDR_W'(idx_x + CMP_W'(1));
              if (idx_x >= cnt_x) begin
                done_next       = 1'b1;
                rsp_next.status = ST_RANGE;
              end else if (idx_x + CMP_W'(1) == cnt_x) begin
                // last entry: nothing to shift
                count_next      = count - 1'b1;
                done_next       = 1'b1;
                rsp_next.status = ST_OK;
              end else begin
                state_next = S_REM;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_FIND: begin
        // rd_data holds the entry at ptr; read ahead at ptr + 1
        ra       = ptr + 1'b1;
        ptr_next = ptr + 1'b1;
        fi       = FIX_W'(ptr);
        if (rd_data == key) begin
          state_next           = S_IDLE;
          done_next            = 1'b1;
          rsp_next.status      = ST_OK;
          rsp_next.found_index = fi[IDX_W-1:0];
        end else if (CNT_W'(ptr) + CNT_W'(1) == count) begin
          state_next      = S_IDLE;
          done_next       = 1'b1;
          rsp_next.status = ST_NOT_FOUND;
        end
      end
      S_MOD: begin
        we                 = 1'b1;
        wa                 = ptr;
        wd                 = key;
        state_next         = S_IDLE;
        done_next          = 1'b1;
        rsp_next.status    = ST_OK;
        rsp_next.old_value = rd_data;
        rsp_next.new_value = key;
      end
      S_REM: begin
        // move entry ptr + 1 down to ptr, read ahead at ptr + 2
        we       = 1'b1;
        wa       = ptr;
        wd       = rd_data;
        ra       = ptr + ADDR_W'(2);
        ptr_next = ptr + 1'b1;
        if (CNT_W'(ptr) + CNT_W'(2) == count) begin
          count_next      = count - 1'b1;
          state_next      = S_IDLE;
          done_next       = 1'b1;
          rsp_next.status = ST_OK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    fx                  = FX_W'(count_next);
    rsp_next.fill_count = fx[FC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    key <= key_next;
    rsp <= rsp_next;
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a walk is still running");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond capacity");

  a_find_walks: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == CMD_FIND && count != '0) |=> busy && !done)
    else $error("find on a non-empty list did not start a walk");

  a_rem_has_tail: assert property (@(posedge clk) disable iff (rst)
    (state == S_REM) |-> (count >= CNT_W'(2)))
    else $error("shift running on a list too short to shift");

  a_rem_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_REM && state_next == S_IDLE) |=> done && count == $past(count) - 1'b1)
    else $error("remove finished without lowering the count");

endmodule
